FILE: design/urnd_pkg.sv
// Shared types and constants for the unsigned restoring / non-restoring divider.
// No dependencies; used by urnd_stage and unsigned_restoring_nonrestoring_divider.
`timescale 1ns / 1ps

package urnd_pkg;

	// Width of the dividend, divisor, quotient and remainder ports
	localparam int FIELD_W   = 32;
	// Default operand width handled by the datapath
	localparam int WIDTH_DEF = 32;

	// Division method codes carried by func
	localparam logic FUNC_RESTORING    = 1'b0;
	localparam logic FUNC_NONRESTORING = 1'b1;

	// Control that travels with every transaction through the pipeline
	typedef struct packed {
		logic valid;
		logic func;
		logic zero;   // dividend is zero: force both results to zero
	} ctl_t;

endpackage

FILE: design/unsigned_restoring_nonrestoring_divider.sv
// Unsigned divider with restoring or non-restoring method, fully pipelined.
// Depends on urnd_pkg and urnd_stage.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid / in_stall) carries func, dividend and divisor; a
//   transaction is taken when in_valid is high and in_stall is low. Output
//   channel (out_valid / out_stall) returns quotient and remainder, one result
//   per input transaction, in order.
//   Pipeline: one stage per quotient bit, each holding one WIDTH+2 bit
//   add/subtract, then one stage for the final remainder correction.
//   Throughput: one transaction per cycle while the skid register is empty.
//   Zero divisor gives an all-ones quotient and the dividend as remainder;
//   zero dividend gives zero for both.
//   Reset clears every stage valid bit and the output skid register; no
//   transaction is in flight afterwards.
//   When out_stall holds off a waiting result, that result moves into a
//   one-entry skid register in the same cycle and the pipeline advances once
//   more; from then on in_stall is high and all stages hold until the skid
//   entry is taken.

module unsigned_restoring_nonrestoring_divider #(
	parameter int WIDTH = urnd_pkg::WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic [urnd_pkg::FIELD_W-1:0] dividend,
	input  logic [urnd_pkg::FIELD_W-1:0] divisor,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [urnd_pkg::FIELD_W-1:0] quotient,
	output logic [urnd_pkg::FIELD_W-1:0] remainder
);

	localparam int RW = WIDTH + 2;
	localparam int FW = urnd_pkg::FIELD_W;

	urnd_pkg::ctl_t   ctl_w [0:WIDTH];
	logic [RW-1:0]    rem_w [0:WIDTH];
	logic [WIDTH-1:0] quo_w [0:WIDTH];
	logic [WIDTH-1:0] den_w [0:WIDTH];

	logic             en;
	logic [WIDTH-1:0] dividend_w;

	// final correction stage
	logic             valid_sn;
	logic [WIDTH-1:0] quo_sn;
	logic [WIDTH-1:0] rem_sn;
	logic [WIDTH-1:0] den_sn;
	logic             zero_sn;
	logic [RW-1:0]    rem_fix;

	// output skid register
	logic             skid_full_q;
	logic [WIDTH-1:0] skid_quo_q;
	logic [WIDTH-1:0] skid_rem_q;

	assign en       = ~skid_full_q;
	assign in_stall = skid_full_q;

	assign dividend_w = WIDTH'(dividend);

	always_comb begin
		ctl_w[0].valid = in_valid;
		ctl_w[0].func  = func;
		ctl_w[0].zero  = (dividend_w == '0);
		rem_w[0]       = '0;
		quo_w[0]       = dividend_w;
		den_w[0]       = WIDTH'(divisor);
	end

	for (genvar k = 0; k < WIDTH; k++) begin : g_stage
		urnd_stage #(
			.WIDTH (WIDTH)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.src_ctl (ctl_w[k]),
			.src_rem (rem_w[k]),
			.src_quo (quo_w[k]),
			.src_den (den_w[k]),
			.ctl     (ctl_w[k+1]),
			.rem     (rem_w[k+1]),
			.quo     (quo_w[k+1]),
			.den     (den_w[k+1])
		);
	end

	always_comb begin
		// non-restoring may end negative: add the divisor back once
		if (ctl_w[WIDTH].func == urnd_pkg::FUNC_NONRESTORING && rem_w[WIDTH][RW-1]) begin
			rem_fix = rem_w[WIDTH] + RW'(den_w[WIDTH]);
		end else begin
			rem_fix = rem_w[WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= ctl_w[WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_sn <= ctl_w[WIDTH].zero;
			den_sn  <= den_w[WIDTH];
			quo_sn  <= ctl_w[WIDTH].zero ? '0 : quo_w[WIDTH];
			rem_sn  <= ctl_w[WIDTH].zero ? '0 : rem_fix[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall) begin
				skid_full_q <= 1'b0;
			end
		end else if (valid_sn && out_stall) begin
			skid_full_q <= 1'b1;
		end
	end

	// capture the stalled result before the pipeline advances over it
	always_ff @(posedge clk) begin
		if (!skid_full_q && valid_sn && out_stall) begin
			skid_quo_q <= quo_sn;
			skid_rem_q <= rem_sn;
		end
	end

	assign out_valid = skid_full_q | valid_sn;
	assign quotient  = FW'(skid_full_q ? skid_quo_q : quo_sn);
	assign remainder = FW'(skid_full_q ? skid_rem_q : rem_sn);

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(valid_sn && out_stall))
		else $error("skid register filled without a stalled result");

	a_skid_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && out_stall |=> skid_full_q)
		else $error("skid entry dropped while output stalled");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sn && den_sn != '0 |-> rem_sn < den_sn)
		else $error("remainder not below divisor");

	a_zero_divisor_quo: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sn && den_sn == '0 && !zero_sn |-> quo_sn == '1)
		else $error("zero divisor did not give all-ones quotient");

endmodule

FILE: design/urnd_stage.sv
// One quotient-bit stage of the divider pipeline: shift, add or subtract, register.
// Depends on urnd_pkg for ctl_t and the method codes.
`timescale 1ns / 1ps

module urnd_stage #(
	parameter int WIDTH = urnd_pkg::WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  urnd_pkg::ctl_t       src_ctl,
	input  logic [WIDTH+1:0]     src_rem,
	input  logic [WIDTH-1:0]     src_quo,
	input  logic [WIDTH-1:0]     src_den,
	output urnd_pkg::ctl_t       ctl,
	output logic [WIDTH+1:0]     rem,
	output logic [WIDTH-1:0]     quo,
	output logic [WIDTH-1:0]     den
);

	localparam int RW = WIDTH + 2;

	urnd_pkg::ctl_t   ctl_s1;
	logic [RW-1:0]    rem_s1;
	logic [WIDTH-1:0] quo_s1;
	logic [WIDTH-1:0] den_s1;

	logic [RW-1:0]    shifted;
	logic [RW-1:0]    diff;
	logic [RW-1:0]    sum;
	logic [RW-1:0]    next_rem;
	logic             qbit;
	logic [WIDTH:0]   quo_ext;

	always_comb begin
		// bring down the next dividend bit from the top of the quotient word
		shifted = {src_rem[RW-2:0], src_quo[WIDTH-1]};
		diff    = shifted - RW'(src_den);
		sum     = shifted + RW'(src_den);
		case (src_ctl.func)
			urnd_pkg::FUNC_RESTORING: begin
				// restore on a negative trial by keeping the shifted value
				next_rem = diff[RW-1] ? shifted : diff;
				qbit     = ~diff[RW-1];
			end
			urnd_pkg::FUNC_NONRESTORING: begin
				next_rem = src_rem[RW-1] ? sum : diff;
				qbit     = ~next_rem[RW-1];
			end
			default: begin
				next_rem = diff;
				qbit     = 1'b0;
			end
		endcase
		quo_ext = {src_quo, qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= src_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= next_rem;
			quo_s1 <= quo_ext[WIDTH-1:0];
			den_s1 <= src_den;
		end
	end

	assign ctl = ctl_s1;
	assign rem = rem_s1;
	assign quo = quo_s1;
	assign den = den_s1;

endmodule

FILE: verif/tb_top.sv
// Self-checking bench for the pipelined unsigned restoring / non-restoring divider.
// Depends on urnd_pkg and unsigned_restoring_nonrestoring_divider; every quotient
// and remainder is checked in order against a local unsigned-division predictor.
`timescale 1ns / 1ps

module tb_top;

	localparam int W         = urnd_pkg::WIDTH_DEF;
	localparam int LATENCY   = W + 1;
	localparam int BURST_MAX = 12;

	typedef logic [urnd_pkg::FIELD_W-1:0] word_t;

	typedef struct {
		logic  func;
		word_t dividend;
		word_t divisor;
		word_t quotient;
		word_t remainder;
	} division_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	logic  func;
	word_t dividend;
	word_t divisor;
	logic  out_valid;
	logic  out_stall;
	word_t quotient;
	word_t remainder;

	division_t pending_divisions[$];

	int mismatch_count  = 0;
	int accepted_count  = 0;
	int checked_count   = 0;
	int zero_div_count  = 0;
	int zero_num_count  = 0;
	int nonrest_count   = 0;
	int tx_idle_pct     = 0;
	int rx_idle_pct     = 0;

	unsigned_restoring_nonrestoring_divider #(.WIDTH(W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Unsigned division with the two special cases: zero dividend wins over zero divisor.
	function automatic division_t predict_division(logic f, word_t num, word_t den);
		division_t d;
		logic [W-1:0] n;
		logic [W-1:0] m;
		n = num[W-1:0];
		m = den[W-1:0];
		d.func = f;
		d.dividend = num;
		d.divisor = den;
		d.quotient = '0;
		d.remainder = '0;
		if (n == '0) begin
			d.quotient = '0;
			d.remainder = '0;
		end else if (m == '0) begin
			d.quotient[W-1:0] = '1;
			d.remainder[W-1:0] = n;
		end else begin
			d.quotient[W-1:0] = n / m;
			d.remainder[W-1:0] = n % m;
		end
		return d;
	endfunction

	function automatic word_t random_operand();
		word_t v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 15);
			1: v = '1 - $urandom_range(0, 15);
			2: v = word_t'(1) << $urandom_range(0, urnd_pkg::FIELD_W - 1);
			3: v = v >> $urandom_range(1, urnd_pkg::FIELD_W - 1);
			4: v = v >> $urandom_range(16, urnd_pkg::FIELD_W - 1);
			default: ;
		endcase
		if ($urandom_range(0, 49) == 0)
			v = '0;
		return v;
	endfunction

	task automatic report_mismatch(string what, division_t d, word_t got, word_t want);
		$display("%0t mismatch %s: func=%0b %h / %h got %h want %h",
			$realtime, what, d.func, d.dividend, d.divisor, got, want);
		mismatch_count++;
	endtask

	// Drive one transaction at the falling edge, hold it until taken, then log the expectation.
	task automatic send_division(logic f, word_t num, word_t den);
		int gap;
		@(negedge clk);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, BURST_MAX);
			in_valid = 1'b0;
			func = 1'($urandom);
			dividend = $urandom;
			divisor = $urandom;
			repeat (gap) @(negedge clk);
		end
		func = f;
		dividend = num;
		divisor = den;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pending_divisions.insert(pending_divisions.size(), predict_division(f, num, den));
		accepted_count++;
		if (num[W-1:0] == '0)
			zero_num_count++;
		else if (den[W-1:0] == '0)
			zero_div_count++;
		if (f == urnd_pkg::FUNC_NONRESTORING)
			nonrest_count++;
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_for_drain();
		hold_input();
		wait (pending_divisions.size() == 0);
	endtask

	// Receiver back-pressure: random stall bursts while enabled.
	initial begin
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_pct == 0) begin
				out_stall = 1'b0;
				burst = 0;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				out_stall = 1'b1;
				burst = $urandom_range(1, BURST_MAX) - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		division_t d;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_divisions.size() == 0) begin
				$display("%0t unexpected result: quotient %h remainder %h",
					$realtime, quotient, remainder);
				mismatch_count++;
			end else begin
				d = pending_divisions.pop_front();
				checked_count++;
				if (quotient !== d.quotient)
					report_mismatch("quotient", d, quotient, d.quotient);
				if (remainder !== d.remainder)
					report_mismatch("remainder", d, remainder, d.remainder);
			end
		end
	end

	// Operand extremes and the zero cases, each method on alternate items.
	task automatic test_directed();
		word_t top;
		word_t nums[12];
		word_t dens[12];
		top = '1;
		nums = '{'0, '0, 32'd5, top, top, top, 32'd1, top - 1,
			32'h8000_0000, 32'h7fff_ffff, 32'd123456789, 32'd100};
		dens = '{'0, 32'd5, '0, '0, 32'd1, top, top, top,
			32'h8000_0000, 32'h8000_0000, 32'd1000, 32'd7};
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 12; i++) begin
			send_division(urnd_pkg::FUNC_RESTORING, nums[i], dens[i]);
			send_division(urnd_pkg::FUNC_NONRESTORING, nums[i], dens[i]);
		end
		send_division(urnd_pkg::FUNC_NONRESTORING, top, 32'd2);
	endtask

	task automatic test_random_stalls(int count);
		tx_idle_pct = 15;
		rx_idle_pct = 10;
		for (int i = 0; i < count; i++) begin
			send_division(1'($urandom_range(0, 1)), random_operand(), random_operand());
			// Change the idling mix now and then, with quiet stretches in between.
			if (i % 200 == 199) begin
				tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
				rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			end
		end
	endtask

	// Let the pipeline empty completely, then restart from idle.
	task automatic test_drain_restart(int count);
		tx_idle_pct = 10;
		rx_idle_pct = 20;
		for (int i = 0; i < count; i++) begin
			send_division(1'($urandom_range(0, 1)), random_operand(), random_operand());
			if (i % 40 == 39)
				wait_for_drain();
		end
		wait_for_drain();
	endtask

	task automatic test_back_to_back(int count);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < count; i++)
			send_division(1'($urandom_range(0, 1)), random_operand(), random_operand());
		hold_input();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = urnd_pkg::FUNC_RESTORING;
		dividend = '0;
		divisor = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_stalls(1000);
		test_drain_restart(200);
		test_back_to_back(280);

		wait (pending_divisions.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d divisions (%0d non-restoring, %0d zero divisor, %0d zero dividend)",
			accepted_count, nonrest_count, zero_div_count, zero_num_count);
		$display("checked %0d results under random input gaps and output stalls",
			checked_count);
		if (mismatch_count == 0 && pending_divisions.size() == 0) begin
			$display("PASS unsigned_restoring_nonrestoring_divider");
		end else begin
			if (pending_divisions.size() != 0)
				$display("%0d results never arrived", pending_divisions.size());
			$display("FAIL unsigned_restoring_nonrestoring_divider");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", pending_divisions.size());
		$display("FAIL unsigned_restoring_nonrestoring_divider");
		$finish;
	end

endmodule
